/* rtl/ahs_pkg.sv */
// ----------------------------------------------------------------------------
// ahs_pkg
// Shared types and constants of the access heat map smoother.
// ----------------------------------------------------------------------------
package ahs_pkg;

   // default sizes of the top level
   localparam int ADDR_BITS_DEF  = 16;
   localparam int COUNT_BITS_DEF = 32;

   // fixed field widths
   localparam int ADDRESS_W   = 16;
   localparam int COUNT_W     = 32;
   localparam int PIXEL_W     = 16;
   localparam int INTENSITY_W = 8;
   localparam int TEXEL_W     = 32;
   localparam int HEAT_W      = 16;
   localparam int WEIGHT_W    = 16;
   localparam int TARGET_W    = 8;
   localparam int CSR_IDX_W   = 1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_ATTACK = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_DECAY  = 1'b1;

   // register reset values (Q0.16)
   localparam logic [WEIGHT_W-1:0] ATTACK_RESET = 16'd13107;
   localparam logic [WEIGHT_W-1:0] DECAY_RESET  = 16'd3277;

   // target heat levels
   localparam logic [TARGET_W-1:0] TARGET_IDLE = 8'd0;
   localparam logic [TARGET_W-1:0] TARGET_ONE  = 8'd128;
   localparam logic [TARGET_W-1:0] TARGET_BUSY = 8'd255;

   // texel alpha byte
   localparam logic [7:0] TEXEL_ALPHA = 8'h88;

   typedef struct packed {
      logic [ADDRESS_W-1:0] address;
      logic [COUNT_W-1:0]   read_count;
      logic [COUNT_W-1:0]   write_count;
   } req_type;

   typedef struct packed {
      logic [PIXEL_W-1:0]     pixel_index;
      logic [INTENSITY_W-1:0] intensity;
      logic [TEXEL_W-1:0]     texel_word;
   } rsp_type;

endpackage

/* rtl/access_heatmap_smoother.sv */
// ----------------------------------------------------------------------------
// access_heatmap_smoother
// Turns per-address access counters into a smoothed heat map held in two
// on-chip memories, one item per cycle while neither rsp_stall nor the clearing pass holds the flow.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_stall  | address, read_count, write_count
//  rsp     | out       | rsp_valid/rsp_stall  | pixel_index, intensity, texel_word
//  csr     | in        | csr_wr_en            | csr_index, csr_wdata
//
//  One item per cycle sustained while rsp_stall is low; the count read happens
//  at the accept edge, the heat read as the item enters stage 2, and the blend
//  loads the result register as the item leaves stage 2, which offers the result.
//  Back-to-back hits on the same address or pixel use a forward register of
//  the most recent write to each memory.
//  After reset a clearing pass zeroes all 2^ADDR_BITS addresses of both memories
//  with req_stall high; csr writes are taken as ever.
//  A stage holds only when the stage after it is full and cannot move.
// ----------------------------------------------------------------------------
module access_heatmap_smoother #(
   parameter int ADDR_BITS  = ahs_pkg::ADDR_BITS_DEF,
   parameter int COUNT_BITS = ahs_pkg::COUNT_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  ahs_pkg::req_type                      req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output ahs_pkg::rsp_type                      rsp_data,
   input  logic                                  csr_wr_en,
   input  logic [ahs_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [ahs_pkg::WEIGHT_W-1:0]          csr_wdata
);

   localparam int DEPTH    = 1 << ADDR_BITS;
   localparam int COL_BITS = (ADDR_BITS + 1) / 2;
   localparam int ROW_BITS = ADDR_BITS / 2;
   localparam int HW       = ahs_pkg::HEAT_W;

   // configuration registers
   logic [ahs_pkg::WEIGHT_W-1:0] attack_ff, decay_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         attack_ff <= ahs_pkg::ATTACK_RESET;
         decay_ff  <= ahs_pkg::DECAY_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            ahs_pkg::REG_ATTACK: attack_ff <= csr_wdata;
            ahs_pkg::REG_DECAY:  decay_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // clearing pass after reset
   logic                 clr_ff;
   logic [ADDR_BITS-1:0] clr_addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff      <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clr_ff) begin
         clr_addr_ff <= clr_addr_ff + 1'b1;
         if (&clr_addr_ff) begin
            clr_ff <= 1'b0;
         end
      end
   end

   // stage enables
   logic v1_ff, v2_ff, rsp_valid_ff;
   logic en_out, en2, en1, accept;

   assign en_out    = !rsp_valid_ff || !rsp_stall;
   assign en2       = en_out || !v2_ff;
   assign en1       = en2 || !v1_ff;
   assign req_stall = clr_ff || !en1;
   assign accept    = req_valid && !req_stall;

   // widen or trim the input fields
   logic [ADDR_BITS-1:0]  addr0, pix0;
   logic [COUNT_BITS-1:0] rd_ext, wr_ext, total0;

   genvar g;
   generate
      for (g = 0; g < ADDR_BITS; g++) begin : g_addr
         if (g < ahs_pkg::ADDRESS_W) begin : g_in
            assign addr0[g] = req_data.address[g];
         end else begin : g_pad
            assign addr0[g] = 1'b0;
         end
      end
      for (g = 0; g < COUNT_BITS; g++) begin : g_cnt
         if (g < ahs_pkg::COUNT_W) begin : g_in
            assign rd_ext[g] = req_data.read_count[g];
            assign wr_ext[g] = req_data.write_count[g];
         end else begin : g_pad
            assign rd_ext[g] = 1'b0;
            assign wr_ext[g] = 1'b0;
         end
      end
      // de-interleave: even bits to the column, odd bits to the row
      for (g = 0; g < COL_BITS; g++) begin : g_col
         assign pix0[g] = addr0[2*g];
      end
      for (g = 0; g < ROW_BITS; g++) begin : g_row
         assign pix0[COL_BITS + g] = addr0[2*g + 1];
      end
   endgenerate

   assign total0 = rd_ext + wr_ext;

   // stage 1 registers
   logic [ADDR_BITS-1:0]  addr1_ff, pix1_ff;
   logic [COUNT_BITS-1:0] total1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en1) begin
         v1_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         addr1_ff  <= addr0;
         pix1_ff   <= pix0;
         total1_ff <= total0;
      end
   end

   // last total memory
   logic [COUNT_BITS-1:0] last_total_mem [DEPTH];
   logic [COUNT_BITS-1:0] lt_rdata_ff, lt_wdata;
   logic [ADDR_BITS-1:0]  lt_waddr;
   logic                  lt_we, lt_upd;

   assign lt_upd   = en2 && v1_ff;
   assign lt_we    = clr_ff || lt_upd;
   assign lt_waddr = clr_ff ? clr_addr_ff : addr1_ff;
   assign lt_wdata = clr_ff ? '0 : total1_ff;

   always_ff @(posedge clock) begin
      if (lt_we) begin
         last_total_mem[lt_waddr] <= lt_wdata;
      end
      if (en1) begin
         lt_rdata_ff <= last_total_mem[addr0];
      end
   end

   // forward the most recent total write
   logic                  lt_fwd_v_ff;
   logic [ADDR_BITS-1:0]  lt_fwd_addr_ff;
   logic [COUNT_BITS-1:0] lt_fwd_total_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         lt_fwd_v_ff <= 1'b0;
      end else if (lt_upd) begin
         lt_fwd_v_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (lt_upd) begin
         lt_fwd_addr_ff  <= addr1_ff;
         lt_fwd_total_ff <= total1_ff;
      end
   end

   // delta against the remembered total picks the target
   logic [COUNT_BITS-1:0]        last1, delta1;
   logic [ahs_pkg::TARGET_W-1:0] target1;

   assign last1  = (lt_fwd_v_ff && (lt_fwd_addr_ff == addr1_ff)) ?
                   lt_fwd_total_ff : lt_rdata_ff;
   assign delta1 = total1_ff - last1;

   always_comb begin
      priority if (delta1 == '0) begin
         target1 = ahs_pkg::TARGET_IDLE;
      end else if (delta1 == COUNT_BITS'(1)) begin
         target1 = ahs_pkg::TARGET_ONE;
      end else begin
         target1 = ahs_pkg::TARGET_BUSY;
      end
   end

   // stage 2 registers
   logic [ADDR_BITS-1:0]         pix2_ff;
   logic [ahs_pkg::TARGET_W-1:0] target2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en2) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         pix2_ff    <= pix1_ff;
         target2_ff <= target1;
      end
   end

   // pixel heat memory
   logic [HW-1:0]        heat_mem [DEPTH];
   logic [HW-1:0]        heat_rdata_ff, heat_wdata, heat2, heat_next;
   logic [ADDR_BITS-1:0] heat_waddr;
   logic                 heat_we, heat_upd;

   assign heat_upd   = en_out && v2_ff;
   assign heat_we    = clr_ff || heat_upd;
   assign heat_waddr = clr_ff ? clr_addr_ff : pix2_ff;
   assign heat_wdata = clr_ff ? '0 : heat_next;

   always_ff @(posedge clock) begin
      if (heat_we) begin
         heat_mem[heat_waddr] <= heat_wdata;
      end
      if (en2) begin
         heat_rdata_ff <= heat_mem[pix1_ff];
      end
   end

   // forward the most recent heat write
   logic                 h_fwd_v_ff;
   logic [ADDR_BITS-1:0] h_fwd_pix_ff;
   logic [HW-1:0]        h_fwd_heat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         h_fwd_v_ff <= 1'b0;
      end else if (heat_upd) begin
         h_fwd_v_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (heat_upd) begin
         h_fwd_pix_ff  <= pix2_ff;
         h_fwd_heat_ff <= heat_next;
      end
   end

   assign heat2 = (h_fwd_v_ff && (h_fwd_pix_ff == pix2_ff)) ? h_fwd_heat_ff : heat_rdata_ff;

   ahs_blend u_blend (
      .heat          (heat2),
      .target        (target2_ff),
      .attack_weight (attack_ff),
      .decay_weight  (decay_ff),
      .heat_next     (heat_next)
   );

   // result register
   logic [ahs_pkg::PIXEL_W-1:0] pix_out;
   ahs_pkg::rsp_type            rsp_ff;

   generate
      for (g = 0; g < ahs_pkg::PIXEL_W; g++) begin : g_pix
         if (g < ADDR_BITS) begin : g_in
            assign pix_out[g] = pix2_ff[g];
         end else begin : g_pad
            assign pix_out[g] = 1'b0;
         end
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en_out) begin
         rsp_valid_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en_out) begin
         rsp_ff.pixel_index <= pix_out;
         rsp_ff.intensity   <= heat_next[HW-1:HW-ahs_pkg::INTENSITY_W];
         rsp_ff.texel_word  <= {ahs_pkg::TEXEL_ALPHA,
                                {(ahs_pkg::TEXEL_W - 8 - ahs_pkg::INTENSITY_W){1'b0}},
                                heat_next[HW-1:HW-ahs_pkg::INTENSITY_W]};
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

/* rtl/ahs_blend.sv */
// ----------------------------------------------------------------------------
// ahs_blend
// Moves an 8.8 heat value toward a target with a Q0.16 weight, rounded half
// up and clamped to the 16-bit range.
// ----------------------------------------------------------------------------
module ahs_blend (
   input  logic [ahs_pkg::HEAT_W-1:0]   heat,
   input  logic [ahs_pkg::TARGET_W-1:0] target,
   input  logic [ahs_pkg::WEIGHT_W-1:0] attack_weight,
   input  logic [ahs_pkg::WEIGHT_W-1:0] decay_weight,
   output logic [ahs_pkg::HEAT_W-1:0]   heat_next
);

   localparam int HW = ahs_pkg::HEAT_W;
   localparam int WW = ahs_pkg::WEIGHT_W;
   localparam int DW = HW + 1;
   localparam int PW = WW + 1 + DW;
   localparam int AW = PW + 1;

   logic [HW-1:0]        goal;
   logic [WW-1:0]        weight;
   logic signed [DW-1:0] diff;
   logic signed [PW-1:0] prod;
   logic signed [AW-1:0] acc;

   // pick the weight by direction of travel
   assign goal   = {target, {(HW - ahs_pkg::TARGET_W){1'b0}}};
   assign weight = (goal > heat) ? attack_weight : decay_weight;

   // heat*65536 + w*(goal - heat) + half
   assign diff = $signed({1'b0, goal}) - $signed({1'b0, heat});
   assign prod = $signed({1'b0, weight}) * diff;
   assign acc  = $signed({{(AW - 2*HW){1'b0}}, heat, {HW{1'b0}}})
               + $signed({prod[PW-1], prod})
               + $signed(AW'(32'd32768));

   // shift down and clamp
   always_comb begin
      priority if (acc[AW-1]) begin
         heat_next = '0;
      end else if (|acc[AW-2:2*HW]) begin
         heat_next = '1;
      end else begin
         heat_next = acc[2*HW-1:HW];
      end
   end

endmodule

/* rtl/ahs_checker.sv */
// ----------------------------------------------------------------------------
// ahs_checker
// Port-level checks of the access heat map smoother, bound to the top level.
// ----------------------------------------------------------------------------
module ahs_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input ahs_pkg::rsp_type rsp_data
);

   // a result waiting on a stall stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp item dropped while stalled");

   // a stalled result keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_data))
      else $error("rsp item changed while stalled");

   // texel word carries alpha and the intensity, zeros between
   a_texel: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.texel_word[31:24] == ahs_pkg::TEXEL_ALPHA) &&
                    (rsp_data.texel_word[23:8] == 16'h0000) &&
                    (rsp_data.texel_word[7:0] == rsp_data.intensity))
      else $error("texel word malformed");

   // after reset the memories are being cleared: no item in, none out
   a_reset_clear: assert property (@(posedge clock)
      $past(reset) |-> req_stall && !rsp_valid)
      else $error("block open right after reset");

endmodule

bind access_heatmap_smoother ahs_checker u_ahs_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
